FILE: src/linear_probe_hash_table_macros.svh
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPHT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPHT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lpht_pkg.sv
// Types, constants and field layout for the linear-probe hash table.
package lpht_pkg;

   // Table geometry; TABLE_DEPTH must be a power of two (home slot is a mask).
   localparam int TABLE_DEPTH = 1024;
   localparam int KEY_BYTES   = 8;
   localparam int VALUE_BITS  = 64;

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KEY_W    = 8 * KEY_BYTES;
   localparam int HASH_W   = 32;

   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_DEPTH - 1);

   // FNV-1a constants
   localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

   // Stream field layout, lowest bit first
   localparam int CMD_W       = 2;
   localparam int KEY_FIELD_W = 64;
   localparam int VAL_FIELD_W = 64;
   localparam int STATUS_W    = 2;

   localparam int REQ_CMD_LSB = 0;
   localparam int REQ_KEY_LSB = REQ_CMD_LSB + CMD_W;
   localparam int REQ_VAL_LSB = REQ_KEY_LSB + KEY_FIELD_W;
   localparam int REQ_BITS    = REQ_VAL_LSB + VAL_FIELD_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   localparam int RSP_BITS    = STATUS_W + VAL_FIELD_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET = 2'd0,
      CMD_GET = 2'd1,
      CMD_DEL = 2'd2,
      CMD_NOP = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_CHECK,
      ST_RESP
   } state_type;

   // One table entry
   typedef struct packed {
      logic                  used;
      logic [KEY_W-1:0]      key;
      logic [VALUE_BITS-1:0] value;
   } slot_type;

   // Slot RAM write port
   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      slot_type            data;
   } ram_wr_type;

   // Hash unit result
   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] hash;
      logic [KEY_W-1:0]  key;
   } hash_res_type;

endpackage

FILE: src/linear_probe_hash_table.sv
// Top level: open-addressing key-value table with FNV-1a home slot and linear probing.
//
//  Channel | Dir | Ports                 | Content
//  req     | in  | req_tvalid/tready     | cmd, key_bytes, put_value
//  rsp     | out | rsp_tvalid/tready     | status, got_value
//
// After reset the slot store is cleared one entry a cycle, all TABLE_DEPTH (1024)
// slots, with req_tready low. A request then hashes its L key bytes (one FNV
// multiply per byte in the shared hash unit) and probes P slots (one slot RAM
// read and compare per cycle). Command 3 skips both and goes straight to the
// response. One request is in flight at a time; a result waiting in the output
// register does not hold off the next accept, only the following response.
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // cmd[1:0], key_bytes[65:2], put_value[129:66], pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // status[1:0], got_value[65:2], pad
);

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   clr_ff,   clr_in;
   cmd_type               cmd_ff,   cmd_in;
   logic [VALUE_BITS-1:0] val_ff,   val_in;
   logic [KEY_W-1:0]      key_ff,   key_in;
   logic [IDX_BITS-1:0]   idx_ff,   idx_in;
   logic [IDX_BITS-1:0]   n_ff,     n_in;
   status_type            res_status_ff, res_status_in;
   logic [VAL_FIELD_W-1:0] res_got_ff,   res_got_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VAL_FIELD_W-1:0] rsp_got_ff,   rsp_got_in;

   logic                  req_beat;
   cmd_type               req_cmd;
   logic                  hash_start;
   hash_res_type          hash_res;
   ram_wr_type            ram_wr;
   logic [IDX_BITS-1:0]   ram_rd_addr;
   slot_type              ram_rd_data;
   logic                  probe_empty, probe_hit, probe_miss;
   logic                  rsp_load;

   assign req_beat = req_tvalid && req_tready;
   assign req_cmd  = cmd_type'(req_tdata[REQ_CMD_LSB +: CMD_W]);

   lpht_hash u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .raw_key (req_tdata[REQ_KEY_LSB +: KEY_W]),
      .res     (hash_res)
   );

   lpht_slot_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // probe outcome for the slot read last cycle
   assign probe_empty = !ram_rd_data.used;
   assign probe_hit   = ram_rd_data.used && (ram_rd_data.key == key_ff);
   assign probe_miss  = ram_rd_data.used && !probe_hit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_beat) state_in = (req_cmd == CMD_NOP) ? ST_RESP : ST_HASH;
         end
         ST_HASH: begin
            if (hash_res.done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!probe_miss || (n_ff == IDX_LAST)) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready     = 1'b0;
      hash_start     = 1'b0;
      rsp_load       = 1'b0;
      ram_wr.en      = 1'b0;
      ram_wr.addr    = idx_ff;
      ram_wr.data    = '{used: (cmd_ff == CMD_SET), key: key_ff, value: val_ff};
      ram_rd_addr    = idx_ff + IDX_BITS'(1);
      case (state_ff)
         ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_ff;
            ram_wr.data = '0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            hash_start = req_tvalid && (req_cmd != CMD_NOP);
         end
         ST_HASH: begin
            ram_rd_addr = hash_res.hash[IDX_BITS-1:0];
         end
         ST_CHECK: begin
            ram_wr.en = (probe_empty && (cmd_ff == CMD_SET)) ||
                        (probe_hit && ((cmd_ff == CMD_SET) || (cmd_ff == CMD_DEL)));
         end
         ST_RESP: begin
            rsp_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      res_status_in = res_status_ff;
      res_got_in    = res_got_ff;
      rsp_status_in = rsp_status_ff;
      rsp_got_in    = rsp_got_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      if (state_ff == ST_CLEAR) clr_in = clr_ff + IDX_BITS'(1);

      // capture request
      if (req_beat) begin
         cmd_in        = req_cmd;
         val_in        = req_tdata[REQ_VAL_LSB +: VALUE_BITS];
         res_status_in = STATUS_OK;
         res_got_in    = '0;
      end

      // home slot
      if ((state_ff == ST_HASH) && hash_res.done) begin
         key_in = hash_res.key;
         idx_in = hash_res.hash[IDX_BITS-1:0];
         n_in   = '0;
      end

      // one probe per cycle
      if (state_ff == ST_CHECK) begin
         idx_in = idx_ff + IDX_BITS'(1);
         n_in   = n_ff + IDX_BITS'(1);
         if (probe_empty) begin
            res_status_in = (cmd_ff == CMD_SET) ? STATUS_OK : STATUS_MISS;
            res_got_in    = '0;
         end else if (probe_hit) begin
            res_status_in = STATUS_OK;
            res_got_in    = (cmd_ff == CMD_GET) ? VAL_FIELD_W'(ram_rd_data.value) : '0;
         end else begin
            res_status_in = STATUS_FULL;
            res_got_in    = '0;
         end
      end

      // output register
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_got_in    = res_got_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_got_ff    <= res_got_in;
      rsp_status_ff <= rsp_status_in;
      rsp_got_ff    <= rsp_got_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_got_ff, rsp_status_ff};

   `LPHT_ASSERT_NOW(a_hash_in_state, clock, reset, hash_res.done, state_ff == ST_HASH, "hash done outside hash state")
   `LPHT_ASSERT_NOW(a_wr_state, clock, reset, ram_wr.en, (state_ff == ST_CLEAR) || (state_ff == ST_CHECK), "slot write outside clear or probe")
   `LPHT_ASSERT_NEXT(a_accept_next, clock, reset, req_beat, (state_ff == ST_HASH) || (state_ff == ST_RESP), "accepted beat not started")
   `LPHT_ASSERT_NEXT(a_full_flag, clock, reset, (state_ff == ST_CHECK) && probe_miss && (n_ff == IDX_LAST), (state_ff == ST_RESP) && (res_status_ff == STATUS_FULL), "full table not flagged")

endmodule

FILE: src/lpht_hash.sv
// Byte-serial FNV-1a hash unit with key normalization, one multiply per beat byte.
`include "linear_probe_hash_table_macros.svh"

module lpht_hash
   import lpht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] raw_key,
   output hash_res_type     res
);

   logic                  busy_ff,  busy_in;
   logic [KEY_BYTES-1:0]  ptr_ff,   ptr_in;
   logic [KEY_W-1:0]      sh_ff,    sh_in;
   logic [KEY_W-1:0]      k_ff,     k_in;
   logic [HASH_W-1:0]     h_ff,     h_in;
   logic [7:0]            byte_w;
   logic                  stop;

   // current byte; the key ends at a zero byte or after the last byte
   assign byte_w = sh_ff[7:0];
   assign stop   = (ptr_ff == '0) || (byte_w == 8'd0);

   assign res.done = busy_ff && stop;
   assign res.hash = h_ff;
   assign res.key  = k_ff;

   // step logic
   always_comb begin
      busy_in = busy_ff;
      ptr_in  = ptr_ff;
      sh_in   = sh_ff;
      k_in    = k_ff;
      h_in    = h_ff;
      if (start) begin
         busy_in = 1'b1;
         ptr_in  = KEY_BYTES'(1);
         sh_in   = raw_key;
         k_in    = '0;
         h_in    = FNV_BASIS;
      end else if (busy_ff) begin
         if (stop) begin
            busy_in = 1'b0;
         end else begin
            h_in   = HASH_W'((h_ff ^ {24'd0, byte_w}) * FNV_PRIME);
            sh_in  = sh_ff >> 8;
            ptr_in = ptr_ff << 1;
            for (int j = 0; j < KEY_BYTES; j++) begin
               if (ptr_ff[j]) begin
                  k_in[8*j +: 8] = byte_w;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      ptr_ff <= ptr_in;
      sh_ff  <= sh_in;
      k_ff   <= k_in;
      h_ff   <= h_in;
   end

   `LPHT_ASSERT_NOW(a_ptr_onehot, clock, reset, busy_ff, $onehot0(ptr_ff), "hash byte pointer not one-hot")
   `LPHT_ASSERT_NEXT(a_done_idle, clock, reset, res.done && !start, !busy_ff, "hash unit still busy after done")
   `LPHT_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && (ptr_ff == KEY_BYTES'(1)), "hash start lost")

endmodule

FILE: src/lpht_slot_ram.sv
// Slot store: one write port, one read port with registered read data.
module lpht_slot_ram
   import lpht_pkg::*;
(
   input  logic                clock,
   input  ram_wr_type          wr,
   input  logic [IDX_BITS-1:0] rd_addr,
   output slot_type            rd_data
);

   slot_type mem [TABLE_DEPTH];
   slot_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/tb_linear_probe_hash_table.sv
// Self-checking testbench for the linear-probe hash table: directed, random and back-pressure traffic.
module tb_linear_probe_hash_table;
   timeunit 1ns;
   timeprecision 1ps;

   import lpht_pkg::*;

   localparam int IDLE_LIMIT    = 8000;  // covers the slot clear after reset
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_GAP       = 13;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 360;
   localparam int POOL_DEPTH    = 64;

   // Expected answer for one request
   typedef struct {
      status_type             status;
      bit [VAL_FIELD_W-1:0]   got_value;
   } answer_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // cmd, key_bytes, put_value, pad
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // status, got_value, pad

   // Shadow copy of the slot store
   bit                    shadow_used  [TABLE_DEPTH];
   bit [KEY_W-1:0]        shadow_key   [TABLE_DEPTH];
   bit [VALUE_BITS-1:0]   shadow_value [TABLE_DEPTH];

   answer_type            answers_due [$];
   bit [KEY_W-1:0]        known_keys [$];
   int                    error_count  = 0;
   int                    quiet_cycles = 0;
   bit                    steady       = 1'b0;  // no idling on either side
   bit                    hold_req     = 1'b0;  // receiver stalls for HOLD_CYCLES

   linear_probe_hash_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Key bytes up to the first zero byte; FNV-1a hash of those bytes
   function automatic bit [KEY_W-1:0] fold_key(input bit [KEY_FIELD_W-1:0] raw,
                                                output bit [HASH_W-1:0] hash);
      bit [KEY_W-1:0]  k;
      bit [HASH_W-1:0] h;
      bit [7:0]        b;
      bit              stop;
      k    = '0;
      h    = FNV_BASIS;
      stop = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         b = raw[8*i +: 8];
         if (b == 8'd0) stop = 1'b1;
         if (!stop) begin
            k[8*i +: 8] = b;
            h = (h ^ {24'd0, b}) * FNV_PRIME;
         end
      end
      hash = h;
      return k;
   endfunction

   // Walk the shadow table for one request, update it, return the answer
   function automatic answer_type apply_table_op(input cmd_type cmd,
                                                 input bit [KEY_FIELD_W-1:0] raw,
                                                 input bit [VAL_FIELD_W-1:0] put);
      answer_type          ans;
      bit [KEY_W-1:0]      k;
      bit [HASH_W-1:0]     h;
      bit [IDX_BITS-1:0]   slot;
      bit                  done;
      ans.status    = STATUS_FULL;
      ans.got_value = '0;
      if (cmd == CMD_NOP) begin
         ans.status = STATUS_OK;
         return ans;
      end
      k    = fold_key(raw, h);
      slot = h[IDX_BITS-1:0];
      done = 1'b0;
      for (int n = 0; n < TABLE_DEPTH && !done; n++) begin
         if (!shadow_used[slot]) begin
            if (cmd == CMD_SET) begin
               shadow_used[slot]  = 1'b1;
               shadow_key[slot]   = k;
               shadow_value[slot] = put[VALUE_BITS-1:0];
               ans.status = STATUS_OK;
            end else begin
               ans.status = STATUS_MISS;
            end
            done = 1'b1;
         end else if (shadow_key[slot] == k) begin
            case (cmd)
               CMD_SET: shadow_value[slot] = put[VALUE_BITS-1:0];
               CMD_GET: ans.got_value = VAL_FIELD_W'(shadow_value[slot]);
               default: begin
                  shadow_used[slot] = 1'b0;  // no tombstone
               end
            endcase
            ans.status = STATUS_OK;
            done = 1'b1;
         end
         slot = slot + IDX_BITS'(1);  // wraps at the table end
      end
      return ans;
   endfunction

   // Random key of min_len..KEY_BYTES bytes, garbage after the terminator
   function automatic bit [KEY_FIELD_W-1:0] fresh_key_bits(input int min_len);
      bit [KEY_FIELD_W-1:0] r;
      int                   len;
      r   = {$urandom, $urandom};
      len = $urandom_range(min_len, KEY_BYTES);
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (i < len && r[8*i +: 8] == 8'd0) r[8*i +: 8] = 8'($urandom_range(1, 255));
         if (i == len) r[8*i +: 8] = 8'd0;
      end
      return r;
   endfunction

   // Same key with new garbage above its terminator
   function automatic bit [KEY_FIELD_W-1:0] dress_key(input bit [KEY_W-1:0] k);
      bit [KEY_FIELD_W-1:0] r;
      bit                   ended;
      r     = {$urandom, $urandom};
      ended = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (!ended) r[8*i +: 8] = k[8*i +: 8];
         if (k[8*i +: 8] == 8'd0) ended = 1'b1;
      end
      return r;
   endfunction

   // Search a three-byte key whose home slot is the given one
   function automatic bit [KEY_FIELD_W-1:0] key_homed_at(input int slot);
      bit [KEY_FIELD_W-1:0] r;
      bit [HASH_W-1:0]      h;
      do begin
         r = {$urandom, $urandom};
         r[7:0]   = 8'($urandom_range(1, 255));
         r[15:8]  = 8'($urandom_range(1, 255));
         r[23:16] = 8'($urandom_range(1, 255));
         r[31:24] = 8'd0;
         void'(fold_key(r, h));
      end while (h[IDX_BITS-1:0] != slot[IDX_BITS-1:0]);
      return r;
   endfunction

   function automatic bit [KEY_FIELD_W-1:0] pick_key();
      if (known_keys.size() > 0 && $urandom_range(0, 9) < 7)
         return dress_key(known_keys[$urandom_range(0, known_keys.size() - 1)]);
      return fresh_key_bits(0);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] MISMATCH %s", $time, what);
   endtask

   // Offer one request beat and record its expected answer on accept
   task automatic send_request(input cmd_type cmd, input bit [KEY_FIELD_W-1:0] key_raw,
                               input bit [VAL_FIELD_W-1:0] put_val);
      int                     gap;
      logic [REQ_TDATA_W-1:0] beat;
      bit [KEY_W-1:0]         norm;
      bit [HASH_W-1:0]        h;
      gap  = steady ? 0 : $urandom_range(0, MAX_GAP);
      beat = '0;
      beat[REQ_CMD_LSB +: CMD_W]       = cmd;
      beat[REQ_KEY_LSB +: KEY_FIELD_W] = key_raw;
      beat[REQ_VAL_LSB +: VAL_FIELD_W] = put_val;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (req_tready !== 1'b1);
      answers_due.push_back(apply_table_op(cmd, key_raw, put_val));
      if (cmd == CMD_SET) begin
         norm = fold_key(key_raw, h);
         if (known_keys.size() < POOL_DEPTH) known_keys.push_back(norm);
         else known_keys[$urandom_range(0, POOL_DEPTH - 1)] = norm;
      end
   endtask

   // Sender stops and waits for every outstanding answer
   task automatic wait_all_answered();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // NOP, miss on empty table, value extremes, empty key, garbage after terminator
   task automatic test_basic_ops();
      bit [KEY_FIELD_W-1:0] absent;
      absent = 64'h0102_0304_0506_0708;
      send_request(CMD_NOP, '1, '1);
      send_request(CMD_GET, absent, '1);
      send_request(CMD_DEL, absent, '0);
      send_request(CMD_SET, '1, '1);
      send_request(CMD_GET, '1, '0);
      send_request(CMD_SET, '1, '0);
      send_request(CMD_GET, '1, '1);
      send_request(CMD_SET, 64'hA5A5_A5A5_A5A5_A500, 64'h0123_4567_89AB_CDEF);
      send_request(CMD_GET, 64'h5A5A_5A5A_5A5A_5A00, '0);
      send_request(CMD_DEL, 64'h0, '0);
      send_request(CMD_GET, 64'hFF00, '0);
      send_request(CMD_SET, 64'hFFFF_FFFF_FFFF_0041, 64'hFEDC_BA98_7654_3210);
      send_request(CMD_GET, 64'h1234_5678_9ABC_0041, '0);
      send_request(CMD_NOP, '0, '0);
      wait_all_answered();
   endtask

   // Collision chain, broken chain after delete, wrap from last slot to slot 0
   task automatic test_probe_chains();
      bit [KEY_FIELD_W-1:0] a, b, c, w1, w2;
      int                   home;
      home = $urandom_range(0, TABLE_DEPTH - 4);
      a  = key_homed_at(home);
      b  = key_homed_at(home);
      c  = key_homed_at(home);
      w1 = key_homed_at(TABLE_DEPTH - 1);
      w2 = key_homed_at(TABLE_DEPTH - 1);
      send_request(CMD_SET, a, {$urandom, $urandom});
      send_request(CMD_SET, b, {$urandom, $urandom});
      send_request(CMD_SET, c, {$urandom, $urandom});
      send_request(CMD_GET, c, '0);
      send_request(CMD_DEL, a, '0);
      send_request(CMD_GET, c, '0);
      send_request(CMD_GET, b, '0);
      send_request(CMD_SET, c, {$urandom, $urandom});
      send_request(CMD_SET, w1, {$urandom, $urandom});
      send_request(CMD_SET, w2, {$urandom, $urandom});
      send_request(CMD_GET, w2, '0);
      wait_all_answered();
   endtask

   // Mixed commands over a pool of live keys, with an idle-free stretch and a drain
   task automatic test_random_traffic();
      int      pick;
      cmd_type cmd;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 120) steady = 1'b1;
         if (i == 200) steady = 1'b0;
         if (i == 260) wait_all_answered();
         pick = $urandom_range(0, 99);
         if (pick < 45)      cmd = CMD_SET;
         else if (pick < 80) cmd = CMD_GET;
         else if (pick < 95) cmd = CMD_DEL;
         else                cmd = CMD_NOP;
         send_request(cmd, pick_key(), {$urandom, $urandom});
      end
      wait_all_answered();
   endtask

   // Receiver stalls long while the sender keeps offering
   task automatic test_output_backpressure();
      hold_req = 1'b1;
      steady   = 1'b1;
      for (int i = 0; i < 10; i++)
         send_request((i % 2) ? CMD_GET : CMD_SET, pick_key(), {$urandom, $urandom});
      steady = 1'b0;
      wait_all_answered();
   endtask

   // Result side: random stalls, compare each beat with the oldest expectation
   initial begin : rsp_sink
      int                   gap;
      answer_type           want;
      logic [STATUS_W-1:0]  got_status;
      logic [VAL_FIELD_W-1:0] got_val;
      forever begin
         if (hold_req) begin
            gap      = HOLD_CYCLES;
            hold_req = 1'b0;
         end else begin
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got_status = rsp_tdata[0 +: STATUS_W];
         got_val    = rsp_tdata[STATUS_W +: VAL_FIELD_W];
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d value %h",
                                      got_status, got_val));
         end else begin
            want = answers_due.pop_front();
            if (got_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
            if (got_val !== want.got_value)
               report_mismatch($sformatf("got_value %h, expected %h", got_val, want.got_value));
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : run
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_probe_chains();
      test_random_traffic();
      test_output_backpressure();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
